// File: rtl/core/rgb_box_mean_filter_top_macros.svh
// Assertion macros for the box mean filter.
`ifndef RGB_BOX_MEAN_FILTER_TOP_MACROS_SVH
`define RGB_BOX_MEAN_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RBMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rbmf assertion failed");
`define RBMF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rbmf assertion failed during reset");
`else
`define RBMF_ASSERT(lbl, prop)
`define RBMF_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/core/rbmf_pkg.sv
// Shared constants and types of the box mean filter.
package rbmf_pkg;
  localparam int PIX_W   = 8;
  localparam int NCH     = 3;
  localparam int CFG_W   = 12;
  localparam int COORD_W = 11;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [1:0]       RADIUS_RST = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_FIN,
    ST_PUSH
  } state_e;
endpackage

// File: rtl/core/rbmf_if.sv
// Pixel stream interfaces: filter input and filter output.
interface rbmf_in_if;
  logic                      valid;
  logic                      ready;
  logic [rbmf_pkg::PIX_W-1:0] blue_in;
  logic [rbmf_pkg::PIX_W-1:0] green_in;
  logic [rbmf_pkg::PIX_W-1:0] red_in;
  modport source (output valid, blue_in, green_in, red_in, input ready);
  modport sink (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface rbmf_out_if;
  logic                        valid;
  logic                        ready;
  logic [rbmf_pkg::PIX_W-1:0]   blue_out;
  logic [rbmf_pkg::PIX_W-1:0]   green_out;
  logic [rbmf_pkg::PIX_W-1:0]   red_out;
  logic [rbmf_pkg::COORD_W-1:0] out_row;
  logic [rbmf_pkg::COORD_W-1:0] out_col;
  logic                        last_of_run;
  modport source (output valid, blue_out, green_out, red_out, out_row, out_col,
                  last_of_run, input ready);
  modport sink (input valid, blue_out, green_out, red_out, out_row, out_col,
                last_of_run, output ready);
endinterface

// File: rtl/core/rgb_box_mean_filter_top.sv
// Box mean filter top: line store, window sequencer and divider cell chain.
// Flow: a request is accepted only while idle; each result it releases is read from
//   the line store, accumulated, divided by the cell chain and registered at the output.
// Input: a new pixel is not taken until every result of the last one has been
//   read through the single line store read port and pushed into the divider chain.
// Reset: size registers 640 x 480, radius 1, frame position zero, no clearing
//   pass; the store is always written before it is read.
`include "rgb_box_mean_filter_top_macros.svh"
module rgb_box_mean_filter_top #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbmf_in_if.sink                       pix_in,
  rbmf_out_if.source                    pix_out,
  input  logic                          cfg_we_i,
  input  logic [rbmf_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [rbmf_pkg::CFG_W-1:0]    cfg_data_i
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RWD   = $clog2(MAX_HEIGHT);
  localparam int SZW   = CW + 1;
  localparam int SZH   = RWD + 1;
  localparam int MW    = (SZW > SZH) ? SZW : SZH;
  localparam int LB    = $clog2(2 * MAX_RADIUS + 1);   // line slot bits, also window step bits
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int NMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW    = $clog2(NMAX + 1);
  localparam int SUMW  = $clog2(255 * NMAX + 1);
  localparam int SW    = ((CW > RWD) ? CW : RWD) + 2;
  localparam int AW    = LB + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int PW    = rbmf_pkg::PIX_W;
  localparam int NCH   = rbmf_pkg::NCH;

  typedef struct packed {
    logic [RWD-1:0] row;
    logic [CW-1:0]  col;
    logic           last;
  } tag_t;

  // ---------------- configuration ----------------
  logic [rbmf_pkg::CFG_W-1:0] width_q, height_q;
  logic [1:0]                 radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbmf_pkg::WIDTH_RST;
      height_q <= rbmf_pkg::HEIGHT_RST;
      radius_q <= rbmf_pkg::RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbmf_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rbmf_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        rbmf_pkg::REG_RADIUS: radius_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and radius; the user must write the registers only while idle, the block does not enforce it.
  logic [SZW-1:0] w_eff;
  logic [SZH-1:0] h_eff;
  logic [MW-1:0]  m_eff;
  logic [RDW-1:0] r_eff;
  logic [LB-1:0]  twor;
  logic [NW-1:0]  n_eff;

  always_comb begin
    logic [RDW-1:0] rc;
    logic [RDW:0]   tp;
    if (width_q == '0)             w_eff = SZW'(1);
    else if (width_q > MAX_WIDTH)  w_eff = SZW'(MAX_WIDTH);
    else                           w_eff = SZW'(width_q);
    if (height_q == '0)            h_eff = SZH'(1);
    else if (height_q > MAX_HEIGHT) h_eff = SZH'(MAX_HEIGHT);
    else                           h_eff = SZH'(height_q);
    m_eff = (MW'(w_eff) < MW'(h_eff)) ? MW'(w_eff) : MW'(h_eff);
    rc = (radius_q > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius_q);
    r_eff = (MW'(rc) > m_eff - MW'(1)) ? RDW'(m_eff - MW'(1)) : rc;
    twor  = LB'({r_eff, 1'b0});
    tp    = {r_eff, 1'b1};
    n_eff = NW'(tp * tp);
  end

  // ---------------- sequencer ----------------
  rbmf_pkg::state_e state_q, state_d;
  logic [RWD-1:0] in_row_q, in_row_d;
  logic [CW-1:0]  in_col_q, in_col_d;
  logic [RWD-1:0] r0_q, r0_d, r1_q, r1_d, oi_q, oi_d;
  logic [CW-1:0]  c1_q, c1_d, oj_q, oj_d;
  logic [LB-1:0]  ky_q, ky_d, kx_q, kx_d;
  logic           rd_v_q;
  logic [NCH-1:0][SUMW-1:0] acc_q, acc_d;
  logic [NCH*PW-1:0]        rdata;

  logic in_acc, in_rdy, issue, head_v, adv, win_end, run_end, have_out;
  logic [RWD-1:0] a_pos, nr0, nr1;
  logic [CW-1:0]  b_pos, nc0, nc1;
  logic           rows_ok, cols_ok;

  assign in_acc = pix_in.valid && in_rdy;

  // Position of the incoming pixel and the span of results it releases.
  always_comb begin
    if (SZW'(in_col_q) >= w_eff || SZH'(in_row_q) >= h_eff) begin
      a_pos = '0;
      b_pos = '0;
    end else begin
      a_pos = in_row_q;
      b_pos = in_col_q;
    end
    rows_ok = 1'b1;
    nr0     = a_pos - RWD'(r_eff);
    nr1     = nr0;
    if (SZH'(a_pos) == h_eff - SZH'(1)) begin
      nr0 = RWD'(h_eff - SZH'(1) - SZH'(r_eff));
      nr1 = RWD'(h_eff - SZH'(1));
    end else if (a_pos < RWD'(r_eff)) begin
      rows_ok = 1'b0;
    end
    cols_ok = 1'b1;
    nc0     = b_pos - CW'(r_eff);
    nc1     = nc0;
    if (SZW'(b_pos) == w_eff - SZW'(1)) begin
      nc0 = CW'(w_eff - SZW'(1) - SZW'(r_eff));
      nc1 = CW'(w_eff - SZW'(1));
    end else if (b_pos < CW'(r_eff)) begin
      cols_ok = 1'b0;
    end
    have_out = rows_ok && cols_ok;
  end

  assign win_end = (ky_q == twor) && (kx_q == twor);
  assign run_end = (oi_q == r1_q) && (oj_q == c1_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbmf_pkg::ST_IDLE: if (in_acc && have_out) state_d = rbmf_pkg::ST_RD;
      rbmf_pkg::ST_RD:   if (win_end) state_d = rbmf_pkg::ST_FIN;
      rbmf_pkg::ST_FIN:  state_d = rbmf_pkg::ST_PUSH;
      rbmf_pkg::ST_PUSH: begin
        if (adv) state_d = run_end ? rbmf_pkg::ST_IDLE : rbmf_pkg::ST_RD;
      end
      default: state_d = rbmf_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_rdy = 1'b0;
    issue  = 1'b0;
    head_v = 1'b0;
    case (state_q)
      rbmf_pkg::ST_IDLE: in_rdy = 1'b1;
      rbmf_pkg::ST_RD:   issue  = 1'b1;
      rbmf_pkg::ST_PUSH: head_v = 1'b1;
      default: ;
    endcase
  end

  assign pix_in.ready = in_rdy;

  // Counters and accumulators
  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    r0_d = r0_q; r1_d = r1_q; c1_d = c1_q;
    oi_d = oi_q; oj_d = oj_q;
    ky_d = ky_q; kx_d = kx_q;
    acc_d = acc_q;
    if (rd_v_q) begin
      for (int c = 0; c < NCH; c++) begin
        acc_d[c] = acc_q[c] + SUMW'(rdata[c*PW +: PW]);
      end
    end
    if (in_acc) begin
      if (SZW'(b_pos) == w_eff - SZW'(1)) begin
        in_col_d = '0;
        in_row_d = (SZH'(a_pos) == h_eff - SZH'(1)) ? '0 : a_pos + RWD'(1);
      end else begin
        in_row_d = a_pos;
        in_col_d = b_pos + CW'(1);
      end
      r0_d = nr0; r1_d = nr1; c1_d = nc1;
      oi_d = nr0; oj_d = nc0;
      ky_d = '0;  kx_d = '0;
      acc_d = '0;
    end
    if (issue) begin
      if (kx_q == twor) begin
        kx_d = '0;
        ky_d = ky_q + LB'(1);
      end else begin
        kx_d = kx_q + LB'(1);
      end
    end
    if (head_v && adv) begin
      acc_d = '0;
      ky_d  = '0;
      kx_d  = '0;
      if (oi_q == r1_q) begin
        oi_d = r0_q;
        oj_d = oj_q + CW'(1);
      end else begin
        oi_d = oi_q + RWD'(1);
      end
    end
    if (cfg_we_i) begin
      // any register write restarts the frame
      in_row_d = '0;
      in_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbmf_pkg::ST_IDLE;
      in_row_q <= '0;
      in_col_q <= '0;
      rd_v_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      rd_v_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;  r1_q <= r1_d;
    c1_q  <= c1_d;
    oi_q  <= oi_d;  oj_q <= oj_d;
    ky_q  <= ky_d;  kx_q <= kx_d;
    acc_q <= acc_d;
  end

  // ---------------- line store ----------------
  // Mirror above/left without the edge, repeat the last r lines below/right.
  logic [AW-1:0]         raddr, waddr;
  logic signed [SW-1:0]  pr, pc, pa;

  always_comb begin
    pr = $signed(SW'(oi_q)) + $signed(SW'(ky_q)) - $signed(SW'(r_eff));
    pc = $signed(SW'(oj_q)) + $signed(SW'(kx_q)) - $signed(SW'(r_eff));
    if (pr < 0)                              pr = -pr;
    else if (pr >= $signed(SW'(h_eff)))      pr = pr - $signed(SW'(r_eff));
    if (pc < 0)                              pc = -pc;
    else if (pc >= $signed(SW'(w_eff)))      pc = pc - $signed(SW'(r_eff));
    pa    = $signed(SW'(a_pos));
    raddr = {pr[LB-1:0], pc[CW-1:0]};
    waddr = {pa[LB-1:0], b_pos};
  end

  rbmf_ram #(
    .WIDTH (NCH * PW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (waddr),
    .wdata_i ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------- divider chain ----------------
  // One cell per quotient bit, MSB first; the whole chain moves when the
  // output register can take a request.
  logic [PW:0]                           ch_v;
  logic [PW:0][NCH-1:0][SUMW-1:0]        ch_rem;
  logic [PW:0][NCH-1:0][PW-1:0]          ch_quot;
  tag_t [PW:0]                           ch_tag;

  assign ch_v[0]        = head_v;
  assign ch_rem[0]      = acc_q;
  assign ch_quot[0]     = '0;
  assign ch_tag[0].row  = oi_q;
  assign ch_tag[0].col  = oj_q;
  assign ch_tag[0].last = run_end;

  for (genvar g = 0; g < PW; g++) begin : g_cell
    rbmf_div_cell #(
      .SUMW  (SUMW),
      .NW    (NW),
      .BIT   (PW - 1 - g),
      .TAG_T (tag_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .div_i   (n_eff),
      .valid_i (ch_v[g]),
      .rem_i   (ch_rem[g]),
      .quot_i  (ch_quot[g]),
      .tag_i   (ch_tag[g]),
      .valid_o (ch_v[g+1]),
      .rem_o   (ch_rem[g+1]),
      .quot_o  (ch_quot[g+1]),
      .tag_o   (ch_tag[g+1])
    );
  end

  // ---------------- output register ----------------
  logic                 out_v_q;
  logic [NCH-1:0][PW-1:0] out_pix_q;
  tag_t                 out_tag_q;

  assign adv = !out_v_q || pix_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= ch_v[PW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= ch_quot[PW];
      out_tag_q <= ch_tag[PW];
    end
  end

  assign pix_out.valid       = out_v_q;
  assign pix_out.blue_out    = out_pix_q[0];
  assign pix_out.green_out   = out_pix_q[1];
  assign pix_out.red_out     = out_pix_q[2];
  assign pix_out.out_row     = rbmf_pkg::COORD_W'(out_tag_q.row);
  assign pix_out.out_col     = rbmf_pkg::COORD_W'(out_tag_q.col);
  assign pix_out.last_of_run = out_tag_q.last;

  // ---------------- checks ----------------
  `RBMF_ASSERT(a_busy_after_hit, (in_acc && have_out) |=> !pix_in.ready)
  `RBMF_ASSERT(a_scan_in_window, (state_q == rbmf_pkg::ST_RD) |-> (ky_q <= twor && kx_q <= twor))
  `RBMF_ASSERT(a_last_ends_run,
               (state_q == rbmf_pkg::ST_PUSH && adv && run_end) |=> state_q == rbmf_pkg::ST_IDLE)
  `RBMF_ASSERT_RST(a_quiet_in_reset, !rst_ni |-> !pix_out.valid)
endmodule

// File: rtl/core/rbmf_ram.sv
// Generic single write port RAM with registered read.
module rbmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/core/rbmf_div_cell.sv
// One cell of the divider chain: resolves one quotient bit per channel.
module rbmf_div_cell #(
  parameter int  SUMW = 16,
  parameter int  NW   = 6,
  parameter int  BIT  = 7,
  parameter type TAG_T = logic
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic [NW-1:0]                             div_i,
  input  logic                                      valid_i,
  input  logic [rbmf_pkg::NCH-1:0][SUMW-1:0]         rem_i,
  input  logic [rbmf_pkg::NCH-1:0][rbmf_pkg::PIX_W-1:0] quot_i,
  input  TAG_T                                      tag_i,
  output logic                                      valid_o,
  output logic [rbmf_pkg::NCH-1:0][SUMW-1:0]         rem_o,
  output logic [rbmf_pkg::NCH-1:0][rbmf_pkg::PIX_W-1:0] quot_o,
  output TAG_T                                      tag_o
);
  logic                                          valid_q;
  logic [rbmf_pkg::NCH-1:0][SUMW-1:0]             rem_q, rem_d;
  logic [rbmf_pkg::NCH-1:0][rbmf_pkg::PIX_W-1:0]  quot_q, quot_d;
  TAG_T                                          tag_q;
  logic [SUMW-1:0]                               dsh;

  assign dsh = SUMW'(div_i) << BIT;

  always_comb begin
    rem_d  = rem_i;
    quot_d = quot_i;
    for (int c = 0; c < rbmf_pkg::NCH; c++) begin
      if (rem_i[c] >= dsh) begin
        rem_d[c]       = rem_i[c] - dsh;
        quot_d[c][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
      tag_q  <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;
  assign tag_o   = tag_q;
endmodule

// File: tb/sv/rgb_box_mean_filter_top_test.sv
// Self-checking testbench for the RGB box mean filter top level.
module rgb_box_mean_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_LINES = 7;
  localparam int STORE_WIDTH = 2048;
  localparam int CYCLE_LIMIT = 1000000;
  // Settle time after the last expected result, with margin.
  localparam int SETTLE      = 200;

  typedef logic [rbmf_pkg::PIX_W-1:0]   pix_t;
  typedef logic [rbmf_pkg::COORD_W-1:0] coord_t;
  typedef logic [rbmf_pkg::CFG_W-1:0]   cfg_word_t;
  typedef logic [rbmf_pkg::IDX_W-1:0]   reg_idx_t;

  typedef struct packed {
    pix_t   blue;
    pix_t   green;
    pix_t   red;
    coord_t row;
    coord_t col;
    logic   last;
  } filtered_pix_t;

  // Scoreboard: models the filter and holds the pixels it should emit.
  class mean_filter_scoreboard;
    logic [23:0]    lines [STORE_LINES*STORE_WIDTH];
    int             cur_row, cur_col;
    int             width_reg, height_reg, radius_reg;
    filtered_pix_t  pending [$];
    int             errors;

    function new();
      cur_row = 0; cur_col = 0;
      width_reg = int'(rbmf_pkg::WIDTH_RST);
      height_reg = int'(rbmf_pkg::HEIGHT_RST);
      radius_reg = int'(rbmf_pkg::RADIUS_RST);
      errors = 0;
      foreach (lines[k]) lines[k] = '0;
    endfunction

    function void write_reg(reg_idx_t idx, cfg_word_t data);
      case (idx)
        rbmf_pkg::REG_WIDTH:  width_reg = int'(data);
        rbmf_pkg::REG_HEIGHT: height_reg = int'(data);
        rbmf_pkg::REG_RADIUS: radius_reg = int'(data[1:0]);
        default: ;
      endcase
      cur_row = 0; cur_col = 0;
    endfunction

    function int fold(int p, int size, int rad);
      if (p < 0) p = -p;
      else if (p >= size) p = p - rad;
      if (p < 0) p = 0;
      if (p > size - 1) p = size - 1;
      return p;
    endfunction

    function filtered_pix_t window_mean(int i, int j, int w, int h, int rad);
      filtered_pix_t res;
      int sb, sg, sr, n, ln, x;
      logic [23:0] v;
      sb = 0; sg = 0; sr = 0;
      for (int dy = -rad; dy <= rad; dy++) begin
        ln = fold(i + dy, h, rad) % STORE_LINES;
        for (int dx = -rad; dx <= rad; dx++) begin
          x = fold(j + dx, w, rad);
          v = lines[ln*STORE_WIDTH + x];
          sb += int'(v[7:0]); sg += int'(v[15:8]); sr += int'(v[23:16]);
        end
      end
      n = (2*rad + 1) * (2*rad + 1);
      res.blue = pix_t'(sb / n); res.green = pix_t'(sg / n); res.red = pix_t'(sr / n);
      res.row = coord_t'(i); res.col = coord_t'(j); res.last = 1'b0;
      return res;
    endfunction

    // Accepted input pixel: store it, queue every window it completes.
    function void note_request(pix_t b, pix_t g, pix_t r);
      int w, h, rad, r0, r1, c0, c1, first;
      w = (width_reg < 1) ? 1 : (width_reg > STORE_WIDTH ? STORE_WIDTH : width_reg);
      h = (height_reg < 1) ? 1 : (height_reg > 2048 ? 2048 : height_reg);
      rad = radius_reg;
      if (rad > ((w < h ? w : h) - 1)) rad = (w < h ? w : h) - 1;
      if (cur_col >= w || cur_row >= h) begin
        cur_col = 0; cur_row = 0;
      end
      lines[(cur_row % STORE_LINES)*STORE_WIDTH + cur_col] = {r, g, b};
      if (cur_row == h - 1) begin r0 = h - 1 - rad; r1 = h - 1; end
      else if (cur_row >= rad) begin r0 = cur_row - rad; r1 = r0; end
      else begin r0 = 0; r1 = -1; end
      if (cur_col == w - 1) begin c0 = w - 1 - rad; c1 = w - 1; end
      else if (cur_col >= rad) begin c0 = cur_col - rad; c1 = c0; end
      else begin c0 = 0; c1 = -1; end
      first = pending.size();
      for (int c = c0; c <= c1; c++)
        for (int rr = r0; rr <= r1; rr++)
          pending.insert(pending.size(), window_mean(rr, c, w, h, rad));
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
      cur_col++;
      if (cur_col >= w) begin
        cur_col = 0; cur_row++;
        if (cur_row >= h) cur_row = 0;
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(filtered_pix_t got);
      filtered_pix_t want;
      if (pending.size() == 0) begin
        report("unexpected pixel, row", 32'(got.row), 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.blue !== want.blue) report("blue", 32'(got.blue), 32'(want.blue));
      if (got.green !== want.green) report("green", 32'(got.green), 32'(want.green));
      if (got.red !== want.red) report("red", 32'(got.red), 32'(want.red));
      if (got.row !== want.row) report("row", 32'(got.row), 32'(want.row));
      if (got.col !== want.col) report("col", 32'(got.col), 32'(want.col));
      if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  reg_idx_t  cfg_idx_i = rbmf_pkg::REG_WIDTH;
  cfg_word_t cfg_data_i = '0;
  int   cycles = 0;
  int   sent = 0;
  bit   calm = 1'b0;      // no idling on either side
  bit   hold_req = 1'b0;  // ask the receiver for a long hold-off
  bit   hold_rx = 1'b0;

  rbmf_in_if  pix_in();
  rbmf_out_if pix_out();

  rgb_box_mean_filter_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_in     (pix_in),
    .pix_out    (pix_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mean_filter_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  initial begin
    pix_in.valid = 1'b0;
    pix_in.blue_in = '0;
    pix_in.green_in = '0;
    pix_in.red_in = '0;
    pix_out.ready = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps going.
  always @(posedge clk_i) begin
    if (hold_req && !hold_rx) begin
      hold_rx <= 1'b1;
      repeat (600) @(posedge clk_i);
      hold_rx <= 1'b0;
    end
  end

  // Output side: check each accepted pixel, then pick next ready.
  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready)
      sb.check_result({pix_out.blue_out, pix_out.green_out, pix_out.red_out,
                       pix_out.out_row, pix_out.out_col, pix_out.last_of_run});
    pix_out.ready <= !hold_rx && (calm || $urandom_range(99) >= 32);
  end

  // One register write; the write enable is low again when the task returns.
  task write_reg(reg_idx_t idx, cfg_word_t data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task set_frame(int w, int h, int rad);
    write_reg(rbmf_pkg::REG_WIDTH, cfg_word_t'(w));
    write_reg(rbmf_pkg::REG_HEIGHT, cfg_word_t'(h));
    write_reg(rbmf_pkg::REG_RADIUS, cfg_word_t'(rad));
  endtask

  // Leaves valid high; the next request or drain decides its level.
  task send_pixel(pix_t b, pix_t g, pix_t r);
    while (!calm && $urandom_range(99) < 32) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid <= 1'b1;
    pix_in.blue_in <= b;
    pix_in.green_in <= g;
    pix_in.red_in <= r;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    sb.note_request(b, g, r);
    sent++;
  endtask

  task send_random(int n);
    for (int k = 0; k < n; k++)
      send_pixel(pix_t'($urandom_range(255)), pix_t'($urandom_range(255)),
                 pix_t'($urandom_range(255)));
  endtask

  // Idle the input until every expected pixel is out, then let it settle.
  task drain();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int w, h, rad, n;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: partial first row, nothing comes out yet.
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    drain();

    // Small frame with extreme values, full edge handling.
    set_frame(4, 3, 1);
    for (int k = 0; k < 12; k++)
      if (k % 2) send_pixel(8'hff, 8'hff, 8'hff);
      else send_pixel(8'h00, 8'hff, 8'h00);
    drain();

    // Zero sizes act as one; radius clamps to zero.
    set_frame(0, 0, 3);
    send_random(2);
    drain();

    // Oversized width, single row: clamp to max width, pass through; then oversized height.
    set_frame(4095, 1, 2);
    send_random(4);
    drain();
    set_frame(2048, 4095, 0);
    send_random(4);
    drain();

    // Largest radius on a frame that allows it.
    set_frame(7, 7, 3);
    send_random(49);
    drain();

    // Receiver holds off while the sender keeps feeding.
    set_frame(8, 6, 0);
    hold_req = 1'b1;
    send_random(30);
    hold_req = 1'b0;
    // Sender pauses mid frame until all results are out.
    drain();
    send_random(18);
    drain();

    // Random frames, mostly whole, some cut short.
    while (sent < 360) begin
      calm = (sent > 200 && sent < 270);
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      rad = $urandom_range(0, 3);
      n = w * h;
      if ($urandom_range(99) < 20) n = $urandom_range(1, n);
      set_frame(w, h, rad);
      send_random(n);
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: rgb_box_mean_filter_top.f
+incdir+rtl/core
rtl/core/rbmf_pkg.sv
rtl/core/rbmf_if.sv
rtl/core/rbmf_ram.sv
rtl/core/rbmf_div_cell.sv
rtl/core/rgb_box_mean_filter_top.sv
tb/sv/rgb_box_mean_filter_top_test.sv
